@@ rtl/pfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pfd_pkg;

    // reset value of the buffer length register
    localparam logic [15:0] BUFFER_LENGTH_RESET = 16'd2048;

    // default depth of the result queue
    localparam int QUEUE_DEPTH = 4;

    // result word kinds
    localparam logic ITEM_FRAME  = 1'b0;
    localparam logic ITEM_STATUS = 1'b1;

    // end-of-buffer status codes
    localparam logic [1:0] RX_NO_MORE   = 2'd0;
    localparam logic [1:0] RX_MORE      = 2'd1;
    localparam logic [1:0] RX_DROPPED   = 2'd2;
    localparam logic [1:0] RX_RESERVED  = 2'd3;

    // input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_last;
    } t_in_word;

    // result word
    typedef struct packed {
        logic       item_kind;
        logic [7:0] frame_byte;
        logic       frame_start;
        logic       frame_end;
        logic       more_in_buffer;
        logic [1:0] rx_status;
        logic       last_result;
    } t_out_word;

    // results produced by one input word, handed to the queue
    typedef struct packed {
        logic [1:0] cnt;
        t_out_word  first;
        t_out_word  second;
    } t_push;

endpackage

`default_nettype wire

@@ rtl/packed_frame_deframer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                   word
// input     in         i_in_valid / o_in_stall     i_in_data  (data_byte, buffer_last)
// output    out        o_out_valid / i_out_stall   o_out_data (frame byte or status)
// config    in         psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// one input word per cycle while o_in_stall is low; its results are queued at the edge that accepts it
// the result words are registered in the queue and offered on the output behind any words queued earlier
// a frame byte gives one result word, the last buffer byte one more (status word)
// o_in_stall rises while the result queue has fewer than two free entries
// synchronous active-low reset clears the parser state, the queue and sets buffer length 2048

module packed_frame_deframer_unit #(
    parameter int QUEUE_DEPTH = pfd_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire pfd_pkg::t_in_word  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output pfd_pkg::t_out_word      o_out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam logic REG_BUFFER_LENGTH = 1'b0;

    logic [15:0]    r_buffer_length;
    logic           in_accept;
    logic           cfg_write;
    pfd_pkg::t_push push;

    // config register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_BUFFER_LENGTH) ? {16'd0, r_buffer_length} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_length <= pfd_pkg::BUFFER_LENGTH_RESET;
        end else if (cfg_write && (paddr[2] == REG_BUFFER_LENGTH)) begin
            r_buffer_length <= pwdata[15:0];
        end
    end

    assign in_accept = i_in_valid && !o_in_stall;

    // byte parser
    pfd_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_in            (i_in_data),
        .i_buffer_length (r_buffer_length),
        .o_push          (push)
    );

    // result queue
    pfd_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_out_stall),
        .o_head  (o_out_data),
        .o_valid (o_out_valid),
        .o_stall (o_in_stall)
    );

`ifndef SYNTHESIS
    // the last byte of a buffer always leaves a status word behind
    a_last_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.buffer_last) |=> o_out_valid)
        else $error("no result word after buffer end");

    // a status word closes the results of its input
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.item_kind == pfd_pkg::ITEM_STATUS))
        |-> o_out_data.last_result)
        else $error("status word without last mark");

    // status code stays in range and frame marks stay clear on status words
    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.item_kind == pfd_pkg::ITEM_STATUS))
        |-> ((o_out_data.rx_status != pfd_pkg::RX_RESERVED) &&
             !o_out_data.frame_start && !o_out_data.frame_end &&
             !o_out_data.more_in_buffer))
        else $error("malformed status word");
`endif

endmodule

`default_nettype wire

@@ rtl/pfd_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pfd_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire pfd_pkg::t_in_word i_in,
    input  wire logic [15:0]      i_buffer_length,
    output pfd_pkg::t_push        o_push
);

    // parse phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_FIRST  = 3'd1;
    localparam logic [2:0] PH_BODY   = 3'd2;
    localparam logic [2:0] PH_CRC    = 3'd3;
    localparam logic [2:0] PH_STOP   = 3'd4;

    localparam logic [15:0] HDR_BYTES = 16'd6;
    localparam logic [15:0] CRC_BYTES = 16'd4;
    localparam logic [15:0] MIN_FRAME = 16'd14;
    localparam logic [31:0] FLAG_MORE = 32'h0000_0010;
    localparam logic [31:0] FLAG_DROP = 32'hFFFF_FFFF;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic [47:0] r_shift, n_shift;
    logic [15:0] r_rem, n_rem;
    logic        r_more_seen, n_more_seen;
    logic        r_frame_more, n_frame_more;
    logic        r_drop, n_drop;

    logic [2:0]  ph;
    logic [47:0] sh;
    logic [15:0] hdr_cnt;
    logic [15:0] len;
    logic [31:0] flags;
    logic [16:0] body_start;
    logic [15:0] flen;
    logic [17:0] frame_end_pos;
    logic [17:0] next_hdr_end;
    logic        is_end;
    logic [15:0] crc_left;
    logic        emit_frame;
    pfd_pkg::t_out_word frame_w;
    pfd_pkg::t_out_word status_w;

    // header field extraction and bounds arithmetic
    assign sh            = {r_shift[39:0], i_in.data_byte};
    assign hdr_cnt       = r_rem + 16'd1;
    assign len           = sh[47:32];
    assign flags         = sh[31:0];
    assign body_start    = {1'b0, r_pos} + 17'd1;
    assign flen          = len - CRC_BYTES;
    assign frame_end_pos = {1'b0, body_start} + {2'b00, flen};
    assign next_hdr_end  = {1'b0, body_start} + {2'b00, len} + {2'b00, HDR_BYTES};
    assign is_end        = (r_rem <= 16'd1);
    assign crc_left      = (r_rem != 16'd0) ? (r_rem - 16'd1) : r_rem;

    // next state and results for the word at the input
    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_shift      = r_shift;
        n_rem        = r_rem;
        n_more_seen  = r_more_seen;
        n_frame_more = r_frame_more;
        n_drop       = r_drop;
        emit_frame   = 1'b0;

        // bytes past the buffer length never belong to a frame
        ph = (r_pos >= i_buffer_length) ? PH_STOP : r_phase;

        unique case (ph)
            PH_HEADER: begin
                n_shift = sh;
                n_rem   = hdr_cnt;
                if (hdr_cnt >= HDR_BYTES) begin
                    if (len == 16'd0) begin
                        n_phase = PH_STOP;
                    end else if (flags == FLAG_DROP) begin
                        n_drop  = 1'b1;
                        n_phase = PH_STOP;
                    end else if (len <= CRC_BYTES) begin
                        n_phase = PH_STOP;
                    end else if (flen < MIN_FRAME) begin
                        n_phase = PH_STOP;
                    end else if (frame_end_pos > {2'b00, i_buffer_length}) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_more_seen  = |(flags & FLAG_MORE);
                        n_frame_more = (|(flags & FLAG_MORE)) &&
                                       (next_hdr_end <= {2'b00, i_buffer_length});
                        n_rem        = flen;
                        n_phase      = PH_FIRST;
                    end
                end else begin
                    n_phase = PH_HEADER;
                end
            end
            PH_FIRST, PH_BODY: begin
                emit_frame = 1'b1;
                if (is_end) begin
                    if (r_more_seen) begin
                        n_phase = PH_CRC;
                        n_rem   = CRC_BYTES;
                    end else begin
                        n_phase = PH_STOP;
                    end
                end else begin
                    n_rem   = r_rem - 16'd1;
                    n_phase = PH_BODY;
                end
            end
            PH_CRC: begin
                n_rem = crc_left;
                if (crc_left == 16'd0) begin
                    n_phase = PH_HEADER;
                    n_shift = 48'd0;
                end else begin
                    n_phase = PH_CRC;
                end
            end
            default: begin
                n_phase = PH_STOP;
            end
        endcase

        // saturating byte offset
        if (r_pos != 16'hFFFF) begin
            n_pos = r_pos + 16'd1;
        end

        // frame byte word
        frame_w.item_kind      = pfd_pkg::ITEM_FRAME;
        frame_w.frame_byte     = i_in.data_byte;
        frame_w.frame_start    = (ph == PH_FIRST);
        frame_w.frame_end      = is_end;
        frame_w.more_in_buffer = r_frame_more;
        frame_w.rx_status      = pfd_pkg::RX_NO_MORE;
        frame_w.last_result    = !i_in.buffer_last;

        // end-of-buffer status word, from this byte's updated flags
        status_w.item_kind      = pfd_pkg::ITEM_STATUS;
        status_w.frame_byte     = 8'd0;
        status_w.frame_start    = 1'b0;
        status_w.frame_end      = 1'b0;
        status_w.more_in_buffer = 1'b0;
        status_w.rx_status      = n_drop ? pfd_pkg::RX_DROPPED :
                                  (n_more_seen ? pfd_pkg::RX_MORE : pfd_pkg::RX_NO_MORE);
        status_w.last_result    = 1'b1;

        // buffer end returns everything to reset
        if (i_in.buffer_last) begin
            n_phase      = PH_HEADER;
            n_pos        = 16'd0;
            n_shift      = 48'd0;
            n_rem        = 16'd0;
            n_more_seen  = 1'b0;
            n_frame_more = 1'b0;
            n_drop       = 1'b0;
        end

        // results toward the queue
        if (emit_frame) begin
            o_push.first  = frame_w;
            o_push.second = status_w;
            o_push.cnt    = i_in.buffer_last ? 2'd2 : 2'd1;
        end else begin
            o_push.first  = status_w;
            o_push.second = status_w;
            o_push.cnt    = i_in.buffer_last ? 2'd1 : 2'd0;
        end
        if (!i_accept) begin
            o_push.cnt = 2'd0;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_pos        <= 16'd0;
            r_shift      <= 48'd0;
            r_rem        <= 16'd0;
            r_more_seen  <= 1'b0;
            r_frame_more <= 1'b0;
            r_drop       <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_shift      <= n_shift;
            r_rem        <= n_rem;
            r_more_seen  <= n_more_seen;
            r_frame_more <= n_frame_more;
            r_drop       <= n_drop;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pfd_out_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pfd_out_queue #(
    parameter int DEPTH = pfd_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pfd_pkg::t_push i_push,
    input  wire logic           i_pop,
    output pfd_pkg::t_out_word  o_head,
    output logic                o_valid,
    output logic                o_stall
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pfd_pkg::t_out_word r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   wr_ptr_1;
    logic               pop;

    // wrap a pointer at the queue depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign wr_ptr_1 = ptr_inc(r_wr_ptr);
    assign pop      = i_pop && (r_count != '0);
    assign o_valid  = (r_count != '0);
    assign o_head   = r_mem[r_rd_ptr];
    // room is kept for the two words one input can cause
    assign o_stall  = (r_count > CNT_W'(DEPTH - 2));

    // pointer and fill arithmetic
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push.cnt == 2'd1) begin
            n_wr_ptr = wr_ptr_1;
        end else if (i_push.cnt == 2'd2) begin
            n_wr_ptr = ptr_inc(wr_ptr_1);
        end
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push.cnt) - CNT_W'(pop);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // word storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.second;
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/packed_frame_deframer_unit_tb.sv @@
`timescale 1ns / 1ps

module packed_frame_deframer_unit_tb;

    import pfd_pkg::*;

    // frame format and run constants
    localparam int          HEADER_BYTES    = 6;
    localparam int          CRC_BYTES       = 4;
    localparam int          MIN_FRAME_BYTES = 14;
    localparam logic [31:0] MORE_BIT        = 32'h0000_0010;
    localparam logic [31:0] DROP_WORD       = 32'hFFFF_FFFF;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          CYCLE_LIMIT     = 400000;

    // register addresses
    localparam logic [2:0] BUFFER_LENGTH_ADDR = 3'd0;
    localparam logic [2:0] UNUSED_ADDR        = 3'd4;

    typedef enum logic [2:0] {
        SCAN_HEADER,
        SCAN_FIRST,
        SCAN_BODY,
        SCAN_CRC,
        SCAN_HALT
    } t_scan_phase;

    // block ports
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_data;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    // deframer prediction state
    logic [15:0] buf_len = BUFFER_LENGTH_RESET;
    logic [15:0] scan_pos;
    t_scan_phase scan_phase;
    logic [47:0] hdr_shift;
    int          remaining;
    logic        more_seen;
    logic        frame_more;
    logic        drop_seen;

    // stimulus and scoreboard storage
    t_in_word    pending_bytes[$];
    t_out_word   expected_words[$];
    logic [7:0]  frame_bytes[$];

    int   sender_idle_pct = 0;
    int   recv_idle_pct   = 0;
    bit   hold_armed      = 1'b0;
    bit   hold_done       = 1'b0;
    int   hold_left       = 0;
    int   error_count     = 0;
    int   words_checked   = 0;
    int   bytes_sent      = 0;
    int   buffers_queued  = 0;
    int   cycle_count     = 0;
    logic timed_out       = 1'b0;

    packed_frame_deframer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run length guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            timed_out <= 1'b1;
        end
    end

    task automatic clear_scan_state();
        scan_pos   = '0;
        scan_phase = SCAN_HEADER;
        hdr_shift  = '0;
        remaining  = 0;
        more_seen  = 1'b0;
        frame_more = 1'b0;
        drop_seen  = 1'b0;
    endtask

    // one buffer byte in, zero to two result words queued as expected
    task automatic deframe_byte(input t_in_word w);
        t_out_word   res [2];
        int          n;
        int          hlen;
        int          body_start;
        logic [31:0] flags;
        n = 0;
        if (scan_pos >= buf_len) begin
            scan_phase = SCAN_HALT;
        end
        case (scan_phase)
            SCAN_HEADER: begin
                hdr_shift = {hdr_shift[39:0], w.data_byte};
                remaining++;
                if (remaining >= HEADER_BYTES) begin
                    hlen       = int'(hdr_shift[47:32]);
                    flags      = hdr_shift[31:0];
                    body_start = int'(scan_pos) + 1;
                    scan_phase = SCAN_HALT;
                    // zero length wins over the drop word
                    if (hlen != 0 && flags == DROP_WORD) begin
                        drop_seen = 1'b1;
                    end else if (hlen > CRC_BYTES && hlen - CRC_BYTES >= MIN_FRAME_BYTES &&
                                 body_start + hlen - CRC_BYTES <= int'(buf_len)) begin
                        more_seen  = (flags & MORE_BIT) != 0;
                        frame_more = more_seen &&
                                     (body_start + hlen + HEADER_BYTES <= int'(buf_len));
                        remaining  = hlen - CRC_BYTES;
                        scan_phase = SCAN_FIRST;
                    end
                end
            end
            SCAN_FIRST, SCAN_BODY: begin
                res[n]                = '0;
                res[n].item_kind      = ITEM_FRAME;
                res[n].frame_byte     = w.data_byte;
                res[n].frame_start    = (scan_phase == SCAN_FIRST);
                res[n].frame_end      = (remaining <= 1);
                res[n].more_in_buffer = frame_more;
                res[n].rx_status      = RX_NO_MORE;
                n++;
                if (remaining <= 1) begin
                    if (more_seen) begin
                        scan_phase = SCAN_CRC;
                        remaining  = CRC_BYTES;
                    end else begin
                        scan_phase = SCAN_HALT;
                    end
                end else begin
                    remaining--;
                    scan_phase = SCAN_BODY;
                end
            end
            SCAN_CRC: begin
                if (remaining > 0) begin
                    remaining--;
                end
                if (remaining == 0) begin
                    scan_phase = SCAN_HEADER;
                    hdr_shift  = '0;
                end
            end
            default: begin
                scan_phase = SCAN_HALT;
            end
        endcase
        if (scan_pos != 16'hFFFF) begin
            scan_pos++;
        end
        // end-of-buffer status word
        if (w.buffer_last) begin
            res[n]           = '0;
            res[n].item_kind = ITEM_STATUS;
            res[n].rx_status = drop_seen ? RX_DROPPED : (more_seen ? RX_MORE : RX_NO_MORE);
            n++;
            clear_scan_state();
        end
        if (n > 0) begin
            res[n-1].last_result = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            expected_words.push_back(res[k]);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // input driver, fed from the pending byte queue
    always @(posedge i_clk) begin : byte_driver
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                deframe_byte(i_in_data);
                bytes_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_bytes.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin : result_monitor
        t_out_word want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("result word %h with nothing expected", o_out_data);
                    error_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("item_kind", 8'(want.item_kind), 8'(o_out_data.item_kind));
                    check_field("frame_byte", want.frame_byte, o_out_data.frame_byte);
                    check_field("frame_start", 8'(want.frame_start),
                                8'(o_out_data.frame_start));
                    check_field("frame_end", 8'(want.frame_end), 8'(o_out_data.frame_end));
                    check_field("more_in_buffer", 8'(want.more_in_buffer),
                                8'(o_out_data.more_in_buffer));
                    check_field("rx_status", 8'(want.rx_status), 8'(o_out_data.rx_status));
                    check_field("last_result", 8'(want.last_result),
                                8'(o_out_data.last_result));
                    words_checked++;
                end
            end
            // long hold-off so the result queue fills and the input stalls
            if (hold_armed && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic apb_access(input logic write_en, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) begin
            @(posedge i_clk);
        end
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_back_length();
        logic [31:0] rd;
        apb_access(1'b0, BUFFER_LENGTH_ADDR, '0, rd);
        if (rd[15:0] !== buf_len) begin
            $error("buffer_length: expected %0h, got %0h", buf_len, rd[15:0]);
            error_count++;
        end
    endtask

    task automatic append_header(input logic [15:0] hlen, input logic [31:0] flags);
        frame_bytes.push_back(hlen[15:8]);
        frame_bytes.push_back(hlen[7:0]);
        frame_bytes.push_back(flags[31:24]);
        frame_bytes.push_back(flags[23:16]);
        frame_bytes.push_back(flags[15:8]);
        frame_bytes.push_back(flags[7:0]);
    endtask

    // mostly well-formed frames, with bad headers mixed in
    task automatic append_frame();
        int          pick;
        int          body;
        logic [15:0] hlen;
        logic [31:0] flags;
        pick  = $urandom_range(99);
        hlen  = 16'($urandom_range(MIN_FRAME_BYTES + CRC_BYTES, 44));
        flags = $urandom;
        if ($urandom_range(99) < 85) begin
            flags = flags | MORE_BIT;
        end else begin
            flags = flags & ~MORE_BIT;
        end
        if (pick < 4) begin
            hlen = '0;
        end else if (pick < 8) begin
            hlen = 16'($urandom_range(1, CRC_BYTES));
        end else if (pick < 12) begin
            hlen = 16'($urandom_range(CRC_BYTES + 1, MIN_FRAME_BYTES + CRC_BYTES - 1));
        end else if (pick < 16) begin
            flags = DROP_WORD;
        end else if (pick < 20) begin
            hlen = 16'($urandom_range(45, 16'hFFFF));
        end
        append_header(hlen, flags);
        body = (hlen > CRC_BYTES) ? int'(hlen) - CRC_BYTES : 0;
        if (body > 44) begin
            body = $urandom_range(0, 44);
        end
        repeat (body + CRC_BYTES) frame_bytes.push_back(8'($urandom));
    endtask

    // hand the first total built bytes to the driver as one buffer
    task automatic send_buffer(input int total);
        t_in_word w;
        for (int k = 0; k < total; k++) begin
            w.data_byte   = frame_bytes[k];
            w.buffer_last = (k == total - 1);
            pending_bytes.push_back(w);
        end
        frame_bytes.delete();
        buffers_queued++;
    endtask

    task automatic wait_drained();
        while (!timed_out && (pending_bytes.size() != 0 || i_in_valid ||
                              expected_words.size() != 0)) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // set the buffer length, then stream random buffers against it
    task automatic run_phase(input logic [15:0] length, input int count, input bit short_bufs);
        int          queued;
        int          total;
        int          pick;
        logic [31:0] rd;
        apb_access(1'b1, BUFFER_LENGTH_ADDR, {16'($urandom), length}, rd);
        buf_len = length;
        read_back_length();
        queued = 0;
        while (queued < count) begin
            pick = $urandom_range(99);
            if (short_bufs) begin
                total = $urandom_range(1, 120);
            end else if (pick < 15) begin
                total = $urandom_range(1, int'(length) - 1);
            end else if (pick < 30) begin
                total = int'(length) + $urandom_range(1, 8);
            end else begin
                total = int'(length);
            end
            while (frame_bytes.size() < total) begin
                append_frame();
            end
            send_buffer(total);
            queued += total;
        end
        wait_drained();
    endtask

    // stimulus sequence
    initial begin
        logic [31:0] rd;
        clear_scan_state();
        sender_idle_pct = 6;
        recv_idle_pct   = 83;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        read_back_length();

        // minimum frame, no more flag, buffer ends on its last byte
        append_header(16'h0012, 32'h0000_0000);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        repeat (12) frame_bytes.push_back(8'($urandom));
        send_buffer(frame_bytes.size());
        // drop word with all-ones length
        append_header(16'hFFFF, DROP_WORD);
        send_buffer(frame_bytes.size());
        wait_drained();

        run_phase(16'd6, 60, 1'b0);
        run_phase(16'd64, 300, 1'b0);

        sender_idle_pct = 83;
        recv_idle_pct   = 6;
        run_phase(16'hFFFF, 200, 1'b1);
        apb_access(1'b1, UNUSED_ADDR, $urandom, rd);
        read_back_length();
        run_phase(16'($urandom_range(20, 150)), 150, 1'b0);
        run_phase(16'($urandom_range(20, 150)), 150, 1'b0);

        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        hold_armed      = 1'b1;
        run_phase(16'd100, 300, 1'b0);

        wait_drained();
        if (timed_out) begin
            $error("cycle limit of %0d reached", CYCLE_LIMIT);
        end
        if (expected_words.size() != 0) begin
            $error("%0d expected result words never arrived", expected_words.size());
            error_count++;
        end
        $display("%0d buffer bytes in %0d buffers produced %0d checked result words",
                 bytes_sent, buffers_queued, words_checked);
        $display("buffer lengths from 6 to 65535, three idle mixes, one long output hold");
        if (!timed_out && error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
